@@ hdl/kct_pkg.sv @@
// Package for the keyed callback table: operation and status codes, hash constants, sequencer states.
`timescale 1ns / 1ps
package kct_pkg;

  // Operation codes
  typedef enum logic [1:0] {
    FN_ADD        = 2'd0,
    FN_REMOVE_ONE = 2'd1,
    FN_REMOVE_ALL = 2'd2,
    FN_NOTIFY     = 2'd3
  } func_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  // Hash: ((key * HASH_MUL) >> HASH_SHIFT) mod buckets over the 64-bit product
  localparam logic [31:0] HASH_MUL   = 32'ha74b2193;
  localparam int          HASH_SHIFT = 16;
  localparam int          HASH_BITS  = 64 - HASH_SHIFT;
  localparam int          MOD_DIGIT  = 4;
  localparam int          MOD_STEPS  = HASH_BITS / MOD_DIGIT;
  localparam int          COUNT_W    = 6;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_MOD,
    S_HEAD,
    S_DISP,
    S_WALK_RD,
    S_WALK_CHK,
    S_REL,
    S_EMIT_RD,
    S_EMIT
  } state_t;

endpackage

@@ hdl/keyed_callback_table.sv @@
// Keyed callback table: chained hash buckets of subscription entries with a free list.
//
//  channel  | signals                                         | handshake
//  ---------+-------------------------------------------------+------------------------------
//  command  | func key handler client                         | taken when start && !busy
//  result   | status matched out_handler out_client           | done strobe, one cycle each
//           | removed_count last                              |
//
// An item is hashed in steps (one multiply, 12 modulo digit steps, one bucket read,
// one dispatch), then each chain link walked takes a read and a check, each entry
// freed a release, and each notify result a read and an emit; the chain walk on the
// single-port entry memories sets the length of an item. Add ends at the dispatch.
// Reset empties all buckets and threads every entry on the free list at once.
// The receiver cannot stall: each result is shown on done for one cycle.
`timescale 1ns / 1ps
module keyed_callback_table #(
  parameter int ENTRIES = 32,
  parameter int BUCKETS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func,
  input  logic [31:0] key,
  input  logic [31:0] handler,
  input  logic [31:0] client,
  output logic        done,
  output logic [1:0]  status,
  output logic        matched,
  output logic [31:0] out_handler,
  output logic [31:0] out_client,
  output logic [kct_pkg::COUNT_W-1:0] removed_count,
  output logic        last
);

  localparam int EW = $clog2(ENTRIES);
  localparam int LW = $clog2(ENTRIES + 1);
  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int RW = $clog2(BUCKETS + 1);
  localparam int CW = $clog2(kct_pkg::MOD_STEPS + 1);
  localparam logic [LW-1:0] NIL = LW'(ENTRIES);

  // Control registers
  kct_pkg::state_t state, state_next;
  kct_pkg::func_t  op, op_next;
  logic [31:0] key_r, key_r_next, hnd_r, hnd_r_next, cli_r, cli_r_next;
  logic [63:0] prod, prod_next;
  logic [RW-1:0] rem, rem_next;
  logic [CW-1:0] dcnt, dcnt_next;
  logic [LW-1:0] cur, cur_next, prev, prev_next, rel, rel_next;
  logic [LW-1:0] free_head, free_head_next;
  logic [LW-1:0] steps, steps_next, hits, hits_next;
  logic [kct_pkg::COUNT_W-1:0] cnt, cnt_next;
  logic        done_next, matched_next, last_next;
  logic [1:0]  status_next;
  logic [31:0] out_handler_next, out_client_next;
  logic [kct_pkg::COUNT_W-1:0] removed_count_next;

  // Memories and their read registers
  logic [LW-1:0] head_mem [BUCKETS];
  logic [BUCKETS-1:0] head_vld;
  logic [LW-1:0] next_mem [ENTRIES];
  logic [ENTRIES-1:0] next_vld;
  logic [31:0] key_mem [ENTRIES];
  logic [31:0] hnd_mem [ENTRIES];
  logic [31:0] cli_mem [ENTRIES];
  logic [63:0] hit_mem [ENTRIES];
  logic [LW-1:0] head_q, next_q;
  logic [31:0] key_q, hnd_q, cli_q;
  logic [63:0] hit_q;

  // Memory port controls
  logic [BW-1:0] bkt;
  logic          hd_we;
  logic [LW-1:0] hd_wdata;
  logic          nx_we;
  logic [EW-1:0] nx_waddr, nx_raddr;
  logic [LW-1:0] nx_wdata;
  logic          dm_we;
  logic          hit_we;
  logic [EW-1:0] hit_raddr;

  // Modulo digit step
  logic [RW:0] mod_t;

  assign bkt  = rem[BW-1:0];
  assign busy = (state != kct_pkg::S_IDLE);

  // Bucket heads: invalid entries read as empty
  always_ff @(posedge clk) begin
    if (rst) begin
      head_vld <= '0;
    end else if (hd_we) begin
      head_vld[bkt] <= 1'b1;
    end
    if (hd_we) begin
      head_mem[bkt] <= hd_wdata;
    end
    head_q <= head_vld[bkt] ? head_mem[bkt] : NIL;
  end

  // Entry links: invalid entries read as the following entry
  always_ff @(posedge clk) begin
    if (rst) begin
      next_vld <= '0;
    end else if (nx_we) begin
      next_vld[nx_waddr] <= 1'b1;
    end
    if (nx_we) begin
      next_mem[nx_waddr] <= nx_wdata;
    end
    next_q <= next_vld[nx_raddr] ? next_mem[nx_raddr] : (LW'(nx_raddr) + LW'(1));
  end

  // Entry payload, written by add at the free head, read along the chain
  always_ff @(posedge clk) begin
    if (dm_we) begin
      key_mem[free_head[EW-1:0]] <= key_r;
      hnd_mem[free_head[EW-1:0]] <= hnd_r;
      cli_mem[free_head[EW-1:0]] <= cli_r;
    end
    key_q <= key_mem[cur[EW-1:0]];
    hnd_q <= hnd_mem[cur[EW-1:0]];
    cli_q <= cli_mem[cur[EW-1:0]];
  end

  // Notify hit stack, popped from the top so the oldest entry comes first
  always_ff @(posedge clk) begin
    if (hit_we) begin
      hit_mem[hits[EW-1:0]] <= {hnd_q, cli_q};
    end
    hit_q <= hit_mem[hit_raddr];
  end

  // Sequencer state and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= kct_pkg::S_IDLE;
      free_head <= '0;
      hits      <= '0;
      done      <= 1'b0;
    end else begin
      state     <= state_next;
      free_head <= free_head_next;
      hits      <= hits_next;
      done      <= done_next;
    end
    op            <= op_next;
    key_r         <= key_r_next;
    hnd_r         <= hnd_r_next;
    cli_r         <= cli_r_next;
    prod          <= prod_next;
    rem           <= rem_next;
    dcnt          <= dcnt_next;
    cur           <= cur_next;
    prev          <= prev_next;
    rel           <= rel_next;
    steps         <= steps_next;
    cnt           <= cnt_next;
    status        <= status_next;
    matched       <= matched_next;
    out_handler   <= out_handler_next;
    out_client    <= out_client_next;
    removed_count <= removed_count_next;
    last          <= last_next;
  end

  // Next state, datapath and memory controls
  always_comb begin
    state_next         = state;
    op_next            = op;
    key_r_next         = key_r;
    hnd_r_next         = hnd_r;
    cli_r_next         = cli_r;
    prod_next          = prod;
    rem_next           = rem;
    dcnt_next          = dcnt;
    cur_next           = cur;
    prev_next          = prev;
    rel_next           = rel;
    free_head_next     = free_head;
    steps_next         = steps;
    hits_next          = hits;
    cnt_next           = cnt;
    done_next          = 1'b0;
    status_next        = status;
    matched_next       = matched;
    out_handler_next   = out_handler;
    out_client_next    = out_client;
    removed_count_next = removed_count;
    last_next          = last;
    hd_we              = 1'b0;
    hd_wdata           = cur;
    nx_we              = 1'b0;
    nx_waddr           = prev[EW-1:0];
    nx_wdata           = next_q;
    nx_raddr           = cur[EW-1:0];
    dm_we              = 1'b0;
    hit_we             = 1'b0;
    hit_raddr          = hits[EW-1:0] - EW'(1);
    mod_t              = '0;

    unique case (state)
      kct_pkg::S_IDLE: begin
        if (start) begin
          op_next    = kct_pkg::func_t'(func);
          key_r_next = key;
          hnd_r_next = handler;
          cli_r_next = client;
          state_next = kct_pkg::S_MUL;
        end
      end

      kct_pkg::S_MUL: begin
        prod_next  = key_r * kct_pkg::HASH_MUL;
        rem_next   = '0;
        dcnt_next  = '0;
        state_next = kct_pkg::S_MOD;
      end

      // Remainder of the shifted product, one nibble per cycle from the top
      kct_pkg::S_MOD: begin
        rem_next = rem;
        for (int i = 0; i < kct_pkg::MOD_DIGIT; i++) begin
          mod_t = {rem_next, prod[63 - i]};
          if (mod_t >= (RW + 1)'(BUCKETS)) begin
            mod_t = mod_t - (RW + 1)'(BUCKETS);
          end
          rem_next = mod_t[RW-1:0];
        end
        prod_next = {prod[63 - kct_pkg::MOD_DIGIT:0], {kct_pkg::MOD_DIGIT{1'b0}}};
        dcnt_next = dcnt + CW'(1);
        if (dcnt == CW'(kct_pkg::MOD_STEPS - 1)) begin
          state_next = kct_pkg::S_HEAD;
        end
      end

      // Bucket head read in flight; the add path also reads the free link
      kct_pkg::S_HEAD: begin
        nx_raddr   = free_head[EW-1:0];
        state_next = kct_pkg::S_DISP;
      end

      kct_pkg::S_DISP: begin
        if (op == kct_pkg::FN_ADD) begin
          done_next          = 1'b1;
          matched_next       = 1'b0;
          out_handler_next   = '0;
          out_client_next    = '0;
          removed_count_next = '0;
          last_next          = 1'b1;
          state_next         = kct_pkg::S_IDLE;
          if (free_head == NIL) begin
            status_next = kct_pkg::ST_FULL;
          end else begin
            status_next    = kct_pkg::ST_OK;
            dm_we          = 1'b1;
            nx_we          = 1'b1;
            nx_waddr       = free_head[EW-1:0];
            nx_wdata       = head_q;
            hd_we          = 1'b1;
            hd_wdata       = free_head;
            free_head_next = next_q;
          end
        end else begin
          cur_next   = head_q;
          prev_next  = NIL;
          steps_next = '0;
          hits_next  = '0;
          cnt_next   = '0;
          state_next = kct_pkg::S_WALK_RD;
        end
      end

      // Issue the entry read, or at the end of the chain or walk bound finish or start emitting hits
      kct_pkg::S_WALK_RD: begin
        if (cur == NIL || steps == LW'(ENTRIES)) begin
          matched_next       = 1'b0;
          out_handler_next   = '0;
          out_client_next    = '0;
          removed_count_next = '0;
          last_next          = 1'b1;
          status_next        = kct_pkg::ST_OK;
          if (op == kct_pkg::FN_NOTIFY && hits != '0) begin
            state_next = kct_pkg::S_EMIT_RD;
          end else begin
            done_next  = 1'b1;
            state_next = kct_pkg::S_IDLE;
            if (op == kct_pkg::FN_REMOVE_ONE) begin
              status_next = kct_pkg::ST_NOT_FOUND;
            end
            if (op == kct_pkg::FN_REMOVE_ALL) begin
              removed_count_next = cnt;
            end
          end
        end else begin
          steps_next = steps + LW'(1);
          state_next = kct_pkg::S_WALK_CHK;
        end
      end

      // Compare the entry; record a notify hit, or unlink on a removal match
      kct_pkg::S_WALK_CHK: begin
        state_next = kct_pkg::S_WALK_RD;
        cur_next   = next_q;
        if (op == kct_pkg::FN_NOTIFY) begin
          if (key_q == key_r) begin
            hit_we    = 1'b1;
            hits_next = hits + LW'(1);
          end
        end else if (key_q == key_r &&
                     (op == kct_pkg::FN_REMOVE_ALL || (hnd_q == hnd_r && cli_q == cli_r))) begin
          if (prev == NIL) begin
            hd_we    = 1'b1;
            hd_wdata = next_q;
          end else begin
            nx_we = 1'b1;
          end
          rel_next   = cur;
          cnt_next   = cnt + kct_pkg::COUNT_W'(1);
          state_next = kct_pkg::S_REL;
        end else begin
          prev_next = cur;
        end
      end

      // Put the unlinked entry back on the free list
      kct_pkg::S_REL: begin
        nx_we          = 1'b1;
        nx_waddr       = rel[EW-1:0];
        nx_wdata       = free_head;
        free_head_next = rel;
        if (op == kct_pkg::FN_REMOVE_ONE) begin
          done_next          = 1'b1;
          status_next        = kct_pkg::ST_OK;
          matched_next       = 1'b0;
          out_handler_next   = '0;
          out_client_next    = '0;
          removed_count_next = '0;
          last_next          = 1'b1;
          state_next         = kct_pkg::S_IDLE;
        end else begin
          state_next = kct_pkg::S_WALK_RD;
        end
      end

      kct_pkg::S_EMIT_RD: begin
        state_next = kct_pkg::S_EMIT;
      end

      kct_pkg::S_EMIT: begin
        done_next          = 1'b1;
        status_next        = kct_pkg::ST_OK;
        matched_next       = 1'b1;
        out_handler_next   = hit_q[63:32];
        out_client_next    = hit_q[31:0];
        removed_count_next = '0;
        last_next          = (hits == LW'(1));
        hits_next          = hits - LW'(1);
        state_next         = (hits == LW'(1)) ? kct_pkg::S_IDLE : kct_pkg::S_EMIT_RD;
      end

      default: begin
        state_next = kct_pkg::S_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  // The final result of an item leaves the block idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst) (done && last) |-> !busy)
    else $error("final result shown while busy");

  // Notified pairs always report success
  a_match_ok: assert property (@(posedge clk) disable iff (rst)
    (done && matched) |-> (status == kct_pkg::ST_OK))
    else $error("notify result with bad status");

  // The hit count never exceeds the pool
  a_hits_range: assert property (@(posedge clk) disable iff (rst) hits <= LW'(ENTRIES))
    else $error("hit count out of range");

  // The free head is an entry or null
  a_free_range: assert property (@(posedge clk) disable iff (rst) free_head <= NIL)
    else $error("free head out of range");

  // An accepted command makes the block busy
  a_start_busy: assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("command not taken");
`endif

endmodule
